// ----- hdl/nlas_pkg.sv -----
// Shared types and constants for the nested loop action sequencer.
// Used by nlas_div, the top level and the bench; depends on nothing.
`timescale 1ns / 1ps

package nlas_pkg;

    // Fixed field widths
    localparam int LEN_W      = 9;
    localparam int OP_W       = 32;
    localparam int TYPE_W     = 4;
    localparam int DLY_W      = 23;
    localparam int REP_W      = 16;
    localparam int SPEED_W    = 7;
    localparam int DIVD_W     = 36;
    localparam int DIVR_W     = 17;
    localparam int DIV_CNT_W  = 6;

    localparam logic [DLY_W-1:0]   DELAY_MAX = 23'd6553500;
    localparam logic [SPEED_W-1:0] SPEED_MIN = 7'd1;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;

    // Configuration register indexes
    localparam logic [1:0] CFG_REPEAT_LIMIT   = 2'd0;
    localparam logic [1:0] CFG_SPEED_TENTHS   = 2'd1;
    localparam logic [1:0] CFG_PROGRAM_LENGTH = 2'd2;

    // Request kinds
    localparam logic [2:0] KIND_LOAD   = 3'd0;
    localparam logic [2:0] KIND_START  = 3'd1;
    localparam logic [2:0] KIND_STEP   = 3'd2;
    localparam logic [2:0] KIND_PAUSE  = 3'd3;
    localparam logic [2:0] KIND_RESUME = 3'd4;
    localparam logic [2:0] KIND_STOP   = 3'd5;

    // Program entry types (6..15 are device actions)
    localparam logic [TYPE_W-1:0] ET_LOOP_START = 4'd0;
    localparam logic [TYPE_W-1:0] ET_LOOP_END   = 4'd1;
    localparam logic [TYPE_W-1:0] ET_DELAY      = 4'd2;
    localparam logic [TYPE_W-1:0] ET_RAND_DELAY = 4'd3;
    localparam logic [TYPE_W-1:0] ET_COMMENT    = 4'd4;
    localparam logic [TYPE_W-1:0] ET_SUBMACRO   = 4'd5;

    // Result status codes
    typedef enum logic [3:0] {
        RS_IGNORED    = 4'd0,
        RS_DEVICE     = 4'd1,
        RS_CONTROL    = 4'd2,
        RS_FINISHED   = 4'd3,
        RS_NO_END     = 4'd4,
        RS_TOO_DEEP   = 4'd5,
        RS_STRAY_END  = 4'd6,
        RS_EMPTY      = 4'd7,
        RS_STARTED    = 4'd8,
        RS_PAUSED     = 4'd9,
        RS_RESUMED    = 4'd10,
        RS_STOPPED    = 4'd11,
        RS_LOADED     = 4'd12
    } status_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_DEC,
        S_SCAN_RD,
        S_SCAN_EV,
        S_STK_EV,
        S_MOD,
        S_SCALE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [7:0]        load_index;
        logic [TYPE_W-1:0] load_type;
        logic [OP_W-1:0]   load_operand;
        logic [15:0]       random_value;
    } cmd_t;

    typedef struct packed {
        logic [3:0]        status;
        logic [LEN_W-1:0]  action_index;
        logic [TYPE_W-1:0] action_type;
        logic [OP_W-1:0]   action_operand;
        logic [DLY_W-1:0]  next_delay_ms;
        logic [REP_W-1:0]  repeat_number;
        logic [LEN_W-1:0]  progress_index;
    } rsp_t;

    typedef struct packed {
        logic [TYPE_W-1:0] etype;
        logic [OP_W-1:0]   operand;
    } entry_t;

    typedef struct packed {
        logic [LEN_W-1:0] start;
        logic [OP_W-1:0]  target;
        logic [OP_W-1:0]  iter;
    } loop_rec_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quot;
        logic [DIVR_W-1:0] rem;
    } div_rsp_t;

    // v * 10 by shifts
    function automatic logic [DIVD_W-1:0] times_ten(input logic [OP_W-1:0] v);
        logic [DIVD_W-1:0] w;
        begin
            w = {4'b0, v};
            times_ten = (w << 3) + (w << 1);
        end
    endfunction

endpackage

// ----- hdl/nlas_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module nlas_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                      wdata,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on we; registered read returns the old contents
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- hdl/nlas_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on nlas_pkg for widths and request/response structs.
`timescale 1ns / 1ps

module nlas_div (
    input  logic               clk,
    input  logic               rst_n,
    input  nlas_pkg::div_req_t req,
    output nlas_pkg::div_rsp_t rsp
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [nlas_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [nlas_pkg::DIVR_W-1:0]       rem_reg;
    logic [nlas_pkg::DIVD_W-1:0]       quot_reg;
    logic [nlas_pkg::DIVR_W-1:0]       div_reg;

    logic [nlas_pkg::DIVR_W:0]         rem_sh;
    logic [nlas_pkg::DIVR_W+1:0]       diff;
    logic                              take;

    // Trial subtract
    assign rem_sh = {rem_reg, quot_reg[nlas_pkg::DIVD_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b0, div_reg};
    assign take   = !diff[nlas_pkg::DIVR_W+1];

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == nlas_pkg::DIV_CNT_W'(1)) && !req.start;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= nlas_pkg::DIV_CNT_W'(nlas_pkg::DIVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - nlas_pkg::DIV_CNT_W'(1);
                if (cnt_reg == nlas_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg <= req.dividend;
            rem_reg  <= '0;
            div_reg  <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= take ? diff[nlas_pkg::DIVR_W-1:0] : rem_sh[nlas_pkg::DIVR_W-1:0];
            quot_reg <= {quot_reg[nlas_pkg::DIVD_W-2:0], take};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ----- hdl/nested_loop_action_sequencer.sv -----
// Nested loop action sequencer: program store, loop stack and playback control.
// Depends on nlas_pkg, nlas_ram (program store, loop stack) and nlas_div.
`timescale 1ns / 1ps

// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) carries load, start, step, pause,
//   resume and stop requests; each gives exactly one response on the rsp
//   channel (rsp_valid/rsp_ready/rsp). cfg channel writes repeat_limit (0),
//   speed_tenths (1) and program_length (2); it is always ready.
//   One request is handled at a time. Load and control requests go
//   straight to the output state. A step reads and decodes its entry;
//   a delay then runs one divide for speed scaling, a random delay a
//   modulo divide then a scaling divide, a loop end updates the loop
//   stack, and a loop start reads entries in turn to find its end.
//   The program store and loop stack are single-port RAMs with registered
//   read data; all entry and loop-record accesses go through them.
//   Reset clears playback state and loads register defaults (repeat 1,
//   speed 10, length 0); store contents are undefined until loaded.
//   A response waits in an output register while rsp_ready is low; the
//   next request is taken meanwhile, and its response holds until free.

module nested_loop_action_sequencer #(
    parameter int PROGRAM_DEPTH = 256,
    parameter int MAX_NESTING   = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  nlas_pkg::cmd_t  cmd,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output nlas_pkg::rsp_t  rsp,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data
);

    localparam int AW        = PROGRAM_DEPTH > 1 ? $clog2(PROGRAM_DEPTH) : 1;
    localparam int SAW       = MAX_NESTING > 1 ? $clog2(MAX_NESTING) : 1;
    localparam int DW        = $clog2(MAX_NESTING + 1);
    localparam int DEPTH_CAP = PROGRAM_DEPTH > 511 ? 511 : PROGRAM_DEPTH;
    localparam int LEN_W     = nlas_pkg::LEN_W;
    localparam int OP_W      = nlas_pkg::OP_W;
    localparam int TYPE_W    = nlas_pkg::TYPE_W;
    localparam int DLY_W     = nlas_pkg::DLY_W;
    localparam int REP_W     = nlas_pkg::REP_W;

    // Configuration registers
    logic [REP_W-1:0]            repeat_limit_reg;
    logic [nlas_pkg::SPEED_W-1:0] speed_reg;
    logic [LEN_W-1:0]            length_reg;

    // Control state
    nlas_pkg::state_t state_reg, state_next;
    logic             playing_reg, playing_next;
    logic             paused_reg, paused_next;
    logic [DW-1:0]    depth_reg, depth_next;
    logic [LEN_W-1:0] next_index_reg, next_index_next;
    logic [REP_W-1:0] repeat_reg, repeat_next;
    logic             rsp_valid_reg;

    // Work registers
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [LEN_W-1:0]  scan_reg, scan_next;
    logic [LEN_W:0]    lvl_reg, lvl_next;
    logic [OP_W-1:0]   cur_op_reg, cur_op_next;
    logic [15:0]       rnd_reg, rnd_next;
    nlas_pkg::status_t res_status_reg, res_status_next;
    logic [LEN_W-1:0]  res_index_reg, res_index_next;
    logic [TYPE_W-1:0] res_type_reg, res_type_next;
    logic [OP_W-1:0]   res_op_reg, res_op_next;
    logic [DLY_W-1:0]  res_dly_reg, res_dly_next;
    nlas_pkg::rsp_t    rsp_reg;

    // Memory ports
    logic                st_we;
    logic [AW-1:0]       st_addr;
    nlas_pkg::entry_t    st_wdata, st_rdata;
    logic                stk_we;
    logic [SAW-1:0]      stk_addr;
    nlas_pkg::loop_rec_t stk_wdata, stk_rdata;

    nlas_pkg::div_req_t  div_req;
    nlas_pkg::div_rsp_t  div_rsp;

    // Shared decode
    logic [LEN_W-1:0]            eff_len;
    logic                        cmd_fire;
    logic                        step_ok;
    logic                        wrap;
    logic [REP_W-1:0]            rep_inc;
    logic                        finish;
    logic [nlas_pkg::SPEED_W-1:0] sp;
    logic [15:0]                 rd_lo, rd_hi;
    logic [OP_W-1:0]             iter1;
    logic                        loop_done;
    logic                        out_free;
    logic [DLY_W-1:0]            sat_dly;
    logic [15:0]                 rand_ms;

    assign eff_len  = (int'(length_reg) > PROGRAM_DEPTH) ? LEN_W'(DEPTH_CAP) : length_reg;
    assign cmd_ready = (state_reg == nlas_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign cmd_fire = cmd_valid && cmd_ready;
    assign step_ok  = playing_reg && !paused_reg;
    assign wrap     = (next_index_reg >= eff_len);
    assign rep_inc  = repeat_reg + REP_W'(1);
    assign finish   = ((repeat_limit_reg != '0) && (rep_inc >= repeat_limit_reg))
                      || (eff_len == '0);
    assign sp       = (speed_reg < nlas_pkg::SPEED_MIN) ? nlas_pkg::SPEED_MIN :
                      (speed_reg > nlas_pkg::SPEED_MAX) ? nlas_pkg::SPEED_MAX : speed_reg;
    assign rd_lo    = st_rdata.operand[15:0];
    assign rd_hi    = st_rdata.operand[31:16];
    assign iter1    = stk_rdata.iter + OP_W'(1);
    assign loop_done = (stk_rdata.target != '0) && (iter1 >= stk_rdata.target);
    assign out_free = !rsp_valid_reg || rsp_ready;
    assign sat_dly  = (div_rsp.quot > nlas_pkg::DIVD_W'(nlas_pkg::DELAY_MAX)) ?
                      nlas_pkg::DELAY_MAX : div_rsp.quot[DLY_W-1:0];
    assign rand_ms  = cur_op_reg[15:0] + div_rsp.rem[15:0];

    nlas_ram #(
        .WIDTH ($bits(nlas_pkg::entry_t)),
        .DEPTH (PROGRAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .addr  (st_addr),
        .wdata (st_wdata),
        .rdata (st_rdata)
    );

    nlas_ram #(
        .WIDTH ($bits(nlas_pkg::loop_rec_t)),
        .DEPTH (MAX_NESTING)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .addr  (stk_addr),
        .wdata (stk_wdata),
        .rdata (stk_rdata)
    );

    nlas_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nlas_pkg::S_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd.kind == nlas_pkg::KIND_STEP && step_ok && !(wrap && finish))
                        state_next = nlas_pkg::S_RD;
                    else
                        state_next = nlas_pkg::S_OUT;
                end
            end
            nlas_pkg::S_RD:
                state_next = nlas_pkg::S_DEC;
            nlas_pkg::S_DEC:
            begin
                case (st_rdata.etype)
                    nlas_pkg::ET_LOOP_START: state_next = nlas_pkg::S_SCAN_RD;
                    nlas_pkg::ET_LOOP_END:
                        state_next = (depth_reg == '0) ? nlas_pkg::S_OUT : nlas_pkg::S_STK_EV;
                    nlas_pkg::ET_DELAY:      state_next = nlas_pkg::S_SCALE;
                    nlas_pkg::ET_RAND_DELAY:
                        state_next = (rd_hi >= rd_lo) ? nlas_pkg::S_MOD : nlas_pkg::S_SCALE;
                    default:                 state_next = nlas_pkg::S_OUT;
                endcase
            end
            nlas_pkg::S_SCAN_RD:
                state_next = (scan_reg >= eff_len) ? nlas_pkg::S_OUT : nlas_pkg::S_SCAN_EV;
            nlas_pkg::S_SCAN_EV:
            begin
                if (st_rdata.etype == nlas_pkg::ET_LOOP_END && lvl_reg == (LEN_W+1)'(1))
                    state_next = nlas_pkg::S_OUT;
                else
                    state_next = nlas_pkg::S_SCAN_RD;
            end
            nlas_pkg::S_STK_EV:
                state_next = nlas_pkg::S_OUT;
            nlas_pkg::S_MOD:
                state_next = div_rsp.done ? nlas_pkg::S_SCALE : nlas_pkg::S_MOD;
            nlas_pkg::S_SCALE:
                state_next = div_rsp.done ? nlas_pkg::S_OUT : nlas_pkg::S_SCALE;
            nlas_pkg::S_OUT:
                state_next = out_free ? nlas_pkg::S_IDLE : nlas_pkg::S_OUT;
            default:
                state_next = nlas_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        playing_next    = playing_reg;
        paused_next     = paused_reg;
        depth_next      = depth_reg;
        next_index_next = next_index_reg;
        repeat_next     = repeat_reg;
        pos_next        = pos_reg;
        scan_next       = scan_reg;
        lvl_next        = lvl_reg;
        cur_op_next     = cur_op_reg;
        rnd_next        = rnd_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_type_next   = res_type_reg;
        res_op_next     = res_op_reg;
        res_dly_next    = res_dly_reg;
        st_we           = 1'b0;
        st_addr         = AW'(next_index_reg);
        st_wdata        = {cmd.load_type, cmd.load_operand};
        stk_we          = 1'b0;
        stk_addr        = SAW'(depth_reg - DW'(1));
        stk_wdata       = '{start: pos_reg, target: cur_op_reg, iter: '0};
        div_req         = '{start: 1'b0,
                            dividend: nlas_pkg::times_ten(st_rdata.operand),
                            divisor: nlas_pkg::DIVR_W'(sp)};

        case (state_reg)
            nlas_pkg::S_IDLE:
            begin
                if (cmd_fire)
                begin
                    res_status_next = nlas_pkg::RS_IGNORED;
                    res_index_next  = '0;
                    res_type_next   = '0;
                    res_op_next     = '0;
                    res_dly_next    = '0;
                    rnd_next        = cmd.random_value;
                    case (cmd.kind)
                        nlas_pkg::KIND_LOAD:
                        begin
                            if (int'(cmd.load_index) < PROGRAM_DEPTH)
                            begin
                                st_we           = 1'b1;
                                st_addr         = AW'(cmd.load_index);
                                res_status_next = nlas_pkg::RS_LOADED;
                                res_index_next  = LEN_W'(cmd.load_index);
                                res_type_next   = cmd.load_type;
                                res_op_next     = cmd.load_operand;
                            end
                        end
                        nlas_pkg::KIND_START:
                        begin
                            paused_next     = 1'b0;
                            depth_next      = '0;
                            next_index_next = '0;
                            repeat_next     = '0;
                            if (eff_len == '0)
                            begin
                                playing_next    = 1'b0;
                                res_status_next = nlas_pkg::RS_EMPTY;
                            end
                            else
                            begin
                                playing_next    = 1'b1;
                                res_status_next = nlas_pkg::RS_STARTED;
                            end
                        end
                        nlas_pkg::KIND_STEP:
                        begin
                            if (step_ok && wrap)
                            begin
                                repeat_next = rep_inc;
                                if (finish)
                                begin
                                    playing_next    = 1'b0;
                                    paused_next     = 1'b0;
                                    depth_next      = '0;
                                    res_status_next = nlas_pkg::RS_FINISHED;
                                end
                                else
                                begin
                                    next_index_next = '0;
                                    depth_next      = '0;
                                end
                            end
                        end
                        nlas_pkg::KIND_PAUSE:
                        begin
                            if (step_ok)
                            begin
                                paused_next     = 1'b1;
                                res_status_next = nlas_pkg::RS_PAUSED;
                            end
                        end
                        nlas_pkg::KIND_RESUME:
                        begin
                            if (playing_reg && paused_reg)
                            begin
                                paused_next     = 1'b0;
                                res_status_next = nlas_pkg::RS_RESUMED;
                            end
                        end
                        nlas_pkg::KIND_STOP:
                        begin
                            if (playing_reg)
                            begin
                                playing_next    = 1'b0;
                                paused_next     = 1'b0;
                                depth_next      = '0;
                                res_status_next = nlas_pkg::RS_STOPPED;
                            end
                        end
                        default:
                        begin
                            res_status_next = nlas_pkg::RS_IGNORED;
                        end
                    endcase
                end
            end

            // Fetch the entry at the play position
            nlas_pkg::S_RD:
            begin
                st_addr  = AW'(next_index_reg);
                pos_next = next_index_reg;
            end

            // Dispatch on entry type
            nlas_pkg::S_DEC:
            begin
                cur_op_next     = st_rdata.operand;
                res_index_next  = pos_reg;
                res_type_next   = st_rdata.etype;
                res_op_next     = st_rdata.operand;
                res_status_next = nlas_pkg::RS_CONTROL;
                case (st_rdata.etype)
                    nlas_pkg::ET_LOOP_START:
                    begin
                        scan_next = pos_reg;
                        lvl_next  = '0;
                    end
                    nlas_pkg::ET_LOOP_END:
                    begin
                        if (depth_reg == '0)
                        begin
                            playing_next    = 1'b0;
                            paused_next     = 1'b0;
                            res_status_next = nlas_pkg::RS_STRAY_END;
                        end
                    end
                    nlas_pkg::ET_DELAY:
                    begin
                        div_req.start = 1'b1;
                    end
                    nlas_pkg::ET_RAND_DELAY:
                    begin
                        div_req.start = 1'b1;
                        if (rd_hi >= rd_lo)
                        begin
                            div_req.dividend = nlas_pkg::DIVD_W'(rnd_reg);
                            div_req.divisor  = {1'b0, rd_hi} - {1'b0, rd_lo}
                                               + nlas_pkg::DIVR_W'(1);
                        end
                        else
                        begin
                            div_req.dividend = nlas_pkg::times_ten(OP_W'(rd_lo));
                        end
                    end
                    nlas_pkg::ET_COMMENT, nlas_pkg::ET_SUBMACRO:
                    begin
                        next_index_next = pos_reg + LEN_W'(1);
                    end
                    default:
                    begin
                        res_status_next = nlas_pkg::RS_DEVICE;
                        res_dly_next    = DLY_W'(1);
                        next_index_next = pos_reg + LEN_W'(1);
                    end
                endcase
            end

            // Search for the matching loop end
            nlas_pkg::S_SCAN_RD:
            begin
                st_addr = AW'(scan_reg);
                if (scan_reg >= eff_len)
                begin
                    playing_next    = 1'b0;
                    paused_next     = 1'b0;
                    depth_next      = '0;
                    res_status_next = nlas_pkg::RS_NO_END;
                end
            end

            nlas_pkg::S_SCAN_EV:
            begin
                scan_next = scan_reg + LEN_W'(1);
                if (st_rdata.etype == nlas_pkg::ET_LOOP_START)
                begin
                    lvl_next = lvl_reg + (LEN_W+1)'(1);
                end
                else if (st_rdata.etype == nlas_pkg::ET_LOOP_END)
                begin
                    lvl_next = lvl_reg - (LEN_W+1)'(1);
                    if (lvl_reg == (LEN_W+1)'(1))
                    begin
                        if (int'(depth_reg) >= MAX_NESTING)
                        begin
                            playing_next    = 1'b0;
                            paused_next     = 1'b0;
                            depth_next      = '0;
                            res_status_next = nlas_pkg::RS_TOO_DEEP;
                        end
                        else
                        begin
                            stk_we          = 1'b1;
                            stk_addr        = SAW'(depth_reg);
                            depth_next      = depth_reg + DW'(1);
                            next_index_next = pos_reg + LEN_W'(1);
                        end
                    end
                end
            end

            // Count an iteration of the innermost loop
            nlas_pkg::S_STK_EV:
            begin
                stk_we    = 1'b1;
                stk_wdata = '{start: stk_rdata.start, target: stk_rdata.target, iter: iter1};
                if (loop_done)
                begin
                    depth_next      = depth_reg - DW'(1);
                    next_index_next = pos_reg + LEN_W'(1);
                end
                else
                begin
                    next_index_next = stk_rdata.start + LEN_W'(1);
                end
            end

            // Random pick done, scale the picked time
            nlas_pkg::S_MOD:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = nlas_pkg::times_ten(OP_W'(rand_ms));
                end
            end

            nlas_pkg::S_SCALE:
            begin
                if (div_rsp.done)
                begin
                    res_dly_next    = sat_dly;
                    next_index_next = pos_reg + LEN_W'(1);
                end
            end

            nlas_pkg::S_OUT:
            begin
                st_we = 1'b0;
            end

            default:
            begin
                st_we = 1'b0;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_limit_reg <= REP_W'(1);
            speed_reg        <= nlas_pkg::SPEED_W'(10);
            length_reg       <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                nlas_pkg::CFG_REPEAT_LIMIT:   repeat_limit_reg <= cfg_data;
                nlas_pkg::CFG_SPEED_TENTHS:   speed_reg <= cfg_data[nlas_pkg::SPEED_W-1:0];
                nlas_pkg::CFG_PROGRAM_LENGTH: length_reg <= cfg_data[LEN_W-1:0];
                default:                      length_reg <= length_reg;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= nlas_pkg::S_IDLE;
            playing_reg    <= 1'b0;
            paused_reg     <= 1'b0;
            depth_reg      <= '0;
            next_index_reg <= '0;
            repeat_reg     <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            playing_reg    <= playing_next;
            paused_reg     <= paused_next;
            depth_reg      <= depth_next;
            next_index_reg <= next_index_next;
            repeat_reg     <= repeat_next;
            if (state_reg == nlas_pkg::S_OUT && out_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Work and output payload registers
    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        scan_reg       <= scan_next;
        lvl_reg        <= lvl_next;
        cur_op_reg     <= cur_op_next;
        rnd_reg        <= rnd_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_type_reg   <= res_type_next;
        res_op_reg     <= res_op_next;
        res_dly_reg    <= res_dly_next;
        if (state_reg == nlas_pkg::S_OUT && out_free)
        begin
            rsp_reg.status         <= res_status_reg;
            rsp_reg.action_index   <= res_index_reg;
            rsp_reg.action_type    <= res_type_reg;
            rsp_reg.action_operand <= res_op_reg;
            rsp_reg.next_delay_ms  <= res_dly_reg;
            rsp_reg.repeat_number  <= repeat_reg;
            rsp_reg.progress_index <= next_index_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- bench/nested_loop_action_sequencer_tb.sv -----
// Self-checking bench for the nested loop action sequencer: directed table, then random programs.
// Depends on nlas_pkg and nested_loop_action_sequencer; carries its own predictor of the block.
`timescale 1ns / 1ps

module nested_loop_action_sequencer_tb;
    import nlas_pkg::*;

    localparam int STORE_DEPTH  = 256;
    localparam int NEST_LIMIT   = 8;
    localparam int ITEM_TARGET  = 850;
    localparam int STALL_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 300;

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_ready;
    cmd_t        cmd;
    logic        rsp_valid;
    logic        rsp_ready;
    rsp_t        rsp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    nested_loop_action_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock, 2 ns period
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Shadow copy of the sequencer state
    logic [3:0]  sh_type [STORE_DEPTH];
    logic [31:0] sh_op   [STORE_DEPTH];
    logic [8:0]  lp_start  [NEST_LIMIT];
    logic [31:0] lp_target [NEST_LIMIT];
    logic [31:0] lp_iter   [NEST_LIMIT];
    int unsigned sh_depth;
    logic [8:0]  sh_next;
    logic [15:0] sh_pass;
    bit          sh_playing;
    bit          sh_paused;
    logic [15:0] rg_repeat;
    logic [6:0]  rg_speed;
    logic [8:0]  rg_length;

    // Program being composed for a phase
    logic [3:0]  pg_type [STORE_DEPTH];
    logic [31:0] pg_op   [STORE_DEPTH];

    rsp_t        pending_rsp[$];
    int          fail_count;
    int          items_sent;
    int          send_idle_pct;
    int          rsp_stall_pct;
    int          hold_token;

    function automatic int unsigned active_length();
        return (rg_length > STORE_DEPTH) ? STORE_DEPTH : rg_length;
    endfunction

    function automatic logic [22:0] scaled_delay(input logic [31:0] ms);
        logic [63:0] sp;
        logic [63:0] d;
        sp = rg_speed;
        if (sp < SPEED_MIN) sp = SPEED_MIN;
        if (sp > SPEED_MAX) sp = SPEED_MAX;
        d = (64'(ms) * 64'd10) / sp;
        return (d > DELAY_MAX) ? DELAY_MAX : d[22:0];
    endfunction

    function automatic rsp_t make_rsp(input status_t st, input logic [8:0] idx,
                                      input logic [3:0] ty, input logic [31:0] op,
                                      input logic [22:0] dly);
        rsp_t r;
        r.status         = st;
        r.action_index   = idx;
        r.action_type    = ty;
        r.action_operand = op;
        r.next_delay_ms  = dly;
        r.repeat_number  = sh_pass;
        r.progress_index = sh_next;
        return r;
    endfunction

    function automatic void stop_playback();
        sh_playing = 1'b0;
        sh_paused  = 1'b0;
        sh_depth   = 0;
    endfunction

    // One program entry executed by a step request
    function automatic rsp_t run_entry(input logic [15:0] rnd);
        int unsigned len;
        int unsigned pos;
        int unsigned lvl;
        logic [3:0]  ty;
        logic [31:0] op;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] ms;
        logic [22:0] dly;
        status_t     st;
        bit          found;
        len = active_length();
        dly = '0;
        st  = RS_CONTROL;
        if (sh_next >= len) begin
            sh_pass = sh_pass + 16'd1;
            if ((rg_repeat > 0 && sh_pass >= rg_repeat) || len == 0) begin
                stop_playback();
                return make_rsp(RS_FINISHED, '0, '0, '0, '0);
            end
            sh_next  = '0;
            sh_depth = 0;
        end
        pos = sh_next;
        ty  = sh_type[pos];
        op  = sh_op[pos];
        case (ty)
            ET_LOOP_START:
            begin
                lvl   = 0;
                found = 1'b0;
                for (int unsigned i = pos; i < len; i++) begin
                    if (sh_type[i] == ET_LOOP_START) lvl++;
                    else if (sh_type[i] == ET_LOOP_END) begin
                        lvl--;
                        if (lvl == 0) begin
                            found = 1'b1;
                            break;
                        end
                    end
                end
                if (!found) begin
                    stop_playback();
                    return make_rsp(RS_NO_END, pos, ty, op, '0);
                end
                if (sh_depth >= NEST_LIMIT) begin
                    stop_playback();
                    return make_rsp(RS_TOO_DEEP, pos, ty, op, '0);
                end
                lp_start[sh_depth]  = pos;
                lp_target[sh_depth] = op;
                lp_iter[sh_depth]   = '0;
                sh_depth++;
                sh_next = pos + 1;
            end
            ET_LOOP_END:
            begin
                if (sh_depth == 0) begin
                    stop_playback();
                    return make_rsp(RS_STRAY_END, pos, ty, op, '0);
                end
                lp_iter[sh_depth-1]++;
                if (lp_target[sh_depth-1] > 0 && lp_iter[sh_depth-1] >= lp_target[sh_depth-1])
                begin
                    sh_depth--;
                    sh_next = pos + 1;
                end
                else begin
                    sh_next = lp_start[sh_depth-1] + 9'd1;
                end
            end
            ET_DELAY:
            begin
                dly     = scaled_delay(op);
                sh_next = pos + 1;
            end
            ET_RAND_DELAY:
            begin
                lo = {16'd0, op[15:0]};
                hi = {16'd0, op[31:16]};
                ms = lo;
                if (hi >= lo) ms = lo + (32'(rnd) % (hi - lo + 1));
                dly     = scaled_delay(ms);
                sh_next = pos + 1;
            end
            ET_COMMENT, ET_SUBMACRO:
                sh_next = pos + 1;
            default:
            begin
                st      = RS_DEVICE;
                dly     = 23'd1;
                sh_next = pos + 1;
            end
        endcase
        return make_rsp(st, pos, ty, op, dly);
    endfunction

    // Expected response of one accepted request
    function automatic rsp_t predict_rsp(input cmd_t c);
        case (c.kind)
            KIND_LOAD:
            begin
                sh_type[c.load_index] = c.load_type;
                sh_op[c.load_index]   = c.load_operand;
                return make_rsp(RS_LOADED, c.load_index, c.load_type, c.load_operand, '0);
            end
            KIND_START:
            begin
                stop_playback();
                sh_next = '0;
                sh_pass = '0;
                if (active_length() == 0) return make_rsp(RS_EMPTY, '0, '0, '0, '0);
                sh_playing = 1'b1;
                return make_rsp(RS_STARTED, '0, '0, '0, '0);
            end
            KIND_STEP:
            begin
                if (!sh_playing || sh_paused) return make_rsp(RS_IGNORED, '0, '0, '0, '0);
                return run_entry(c.random_value);
            end
            KIND_PAUSE:
            begin
                if (!sh_playing || sh_paused) return make_rsp(RS_IGNORED, '0, '0, '0, '0);
                sh_paused = 1'b1;
                return make_rsp(RS_PAUSED, '0, '0, '0, '0);
            end
            KIND_RESUME:
            begin
                if (!sh_playing || !sh_paused) return make_rsp(RS_IGNORED, '0, '0, '0, '0);
                sh_paused = 1'b0;
                return make_rsp(RS_RESUMED, '0, '0, '0, '0);
            end
            KIND_STOP:
            begin
                if (!sh_playing) return make_rsp(RS_IGNORED, '0, '0, '0, '0);
                stop_playback();
                return make_rsp(RS_STOPPED, '0, '0, '0, '0);
            end
            default:
                return make_rsp(RS_IGNORED, '0, '0, '0, '0);
        endcase
    endfunction

    // Send one request; the expectation is taken at acceptance
    task automatic send_request(input cmd_t c, input bit fixed, input rsp_t fixed_rsp);
        rsp_t r;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_valid = 1'b0;
            @(negedge clk);
        end
        cmd_valid = 1'b1;
        cmd       = c;
        do @(posedge clk); while (!cmd_ready);
        r = predict_rsp(c);
        pending_rsp.push_back(fixed ? fixed_rsp : r);
        items_sent++;
    endtask

    task automatic send_plain(input cmd_t c);
        send_request(c, 1'b0, '0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cmd_valid = 1'b0;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_REPEAT_LIMIT:   rg_repeat = data;
            CFG_SPEED_TENTHS:   rg_speed  = data[6:0];
            CFG_PROGRAM_LENGTH: rg_length = data[8:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        cmd_valid = 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
    endtask

    function automatic cmd_t random_cmd(input logic [2:0] kind);
        cmd_t c;
        c.kind         = kind;
        c.load_index   = $urandom;
        c.load_type    = $urandom;
        c.load_operand = $urandom;
        c.random_value = $urandom;
        return c;
    endfunction

    function automatic logic [31:0] entry_operand(input logic [3:0] ty);
        case (ty)
            ET_LOOP_START:
                return $urandom_range(3);
            ET_DELAY, ET_RAND_DELAY:
                return ($urandom_range(3) == 0) ? $urandom
                       : {16'($urandom_range(800)), 16'($urandom_range(400))};
            default:
                return $urandom;
        endcase
    endfunction

    // Mostly well-nested programs; broken ones take any type anywhere
    function automatic void compose_program(input int n, input bit broken);
        int          open;
        int          left;
        int          pick;
        logic [3:0]  ty;
        open = 0;
        for (int i = 0; i < n; i++) begin
            left = n - i;
            pick = $urandom_range(9);
            if (broken) ty = $urandom;
            else if (open > 0 && left == open) begin
                ty = ET_LOOP_END;
                open--;
            end
            else if (pick < 2 && open < NEST_LIMIT && left > open + 1) begin
                ty = ET_LOOP_START;
                open++;
            end
            else if (pick < 4 && open > 0) begin
                ty = ET_LOOP_END;
                open--;
            end
            else ty = $urandom_range(ET_DELAY, 15);
            pg_type[i] = ty;
            pg_op[i]   = entry_operand(ty);
        end
    endfunction

    function automatic void compose_too_deep();
        for (int i = 0; i <= NEST_LIMIT; i++) begin
            pg_type[i]                  = ET_LOOP_START;
            pg_op[i]                    = 32'd1;
            pg_type[2*NEST_LIMIT+1-i]   = ET_LOOP_END;
            pg_op[2*NEST_LIMIT+1-i]     = $urandom;
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Receiver: random stalls plus a long hold-off on request
    int hold_seen;
    int hold_left;
    always @(negedge clk)
    begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
        end
        else rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
    end

    // Response checker
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
                $error("response with none expected: status %0d", rsp.status);
                fail_count++;
            end
            else begin
                want = pending_rsp.pop_front();
                check_field("status", want.status, rsp.status);
                check_field("action_index", want.action_index, rsp.action_index);
                check_field("action_type", want.action_type, rsp.action_type);
                check_field("action_operand", want.action_operand, rsp.action_operand);
                check_field("next_delay_ms", want.next_delay_ms, rsp.next_delay_ms);
                check_field("repeat_number", want.repeat_number, rsp.repeat_number);
                check_field("progress_index", want.progress_index, rsp.progress_index);
            end
        end
    end

    // Watchdog on cycles without any handshake
    int quiet_cycles;
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    typedef struct {
        cmd_t c;
        bit   fixed;
        rsp_t r;
    } table_row_t;

    table_row_t  dir_rows[$];

    function automatic table_row_t row(input logic [2:0] kind, input logic [7:0] idx,
                                       input logic [3:0] ty, input logic [31:0] op,
                                       input logic [15:0] rnd, input bit fixed,
                                       input status_t st);
        table_row_t t;
        t.c     = '{kind: kind, load_index: idx, load_type: ty, load_operand: op,
                    random_value: rnd};
        t.fixed = fixed;
        t.r     = '0;
        t.r.status = st;
        if (kind == KIND_LOAD) begin
            t.r.action_index   = idx;
            t.r.action_type    = ty;
            t.r.action_operand = op;
        end
        return t;
    endfunction

    initial
    begin
        int          scen;
        int          len;
        int          steps;
        bit          broken;
        logic [15:0] rep_pick;
        logic [15:0] spd_pick;
        logic [15:0] len_pick;

        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        cmd           = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        rsp_ready     = 1'b0;
        fail_count    = 0;
        items_sent    = 0;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        hold_token    = 0;
        hold_seen     = 0;
        hold_left     = 0;
        quiet_cycles  = 0;
        sh_depth      = 0;
        sh_next       = '0;
        sh_pass       = '0;
        sh_playing    = 1'b0;
        sh_paused     = 1'b0;
        rg_repeat     = 16'd1;
        rg_speed      = 7'd10;
        rg_length     = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: control in the wrong state, empty start, unknown kinds, store extremes
        dir_rows.push_back(row(KIND_STEP,   8'd0, 4'd0, 32'd0, 16'hFFFF, 1'b1, RS_IGNORED));
        dir_rows.push_back(row(KIND_PAUSE,  8'd0, 4'd0, 32'd0, 16'd0, 1'b1, RS_IGNORED));
        dir_rows.push_back(row(KIND_RESUME, 8'd0, 4'd0, 32'd0, 16'd0, 1'b1, RS_IGNORED));
        dir_rows.push_back(row(KIND_STOP,   8'd0, 4'd0, 32'd0, 16'd0, 1'b1, RS_IGNORED));
        dir_rows.push_back(row(KIND_START,  8'd0, 4'd0, 32'd0, 16'd0, 1'b1, RS_EMPTY));
        dir_rows.push_back(row(3'd6, 8'hFF, 4'hF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, RS_IGNORED));
        dir_rows.push_back(row(3'd7, 8'd0, 4'd0, 32'd0, 16'd0, 1'b1, RS_IGNORED));
        dir_rows.push_back(row(KIND_LOAD, 8'hFF, 4'hF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                               RS_LOADED));
        dir_rows.push_back(row(KIND_LOAD, 8'd0, ET_LOOP_START, 32'd0, 16'd0, 1'b1,
                               RS_LOADED));
        dir_rows.push_back(row(KIND_LOAD, 8'd1, ET_LOOP_END, 32'd0, 16'd0, 1'b0,
                               RS_LOADED));
        foreach (dir_rows[i]) send_request(dir_rows[i].c, dir_rows[i].fixed, dir_rows[i].r);

        // Fill the whole store so no step ever reads an unwritten entry
        for (int i = 2; i < STORE_DEPTH; i++) begin
            cmd_t c;
            c = random_cmd(KIND_LOAD);
            c.load_index = i;
            send_plain(c);
        end

        // Random playback phases
        scen = 0;
        while (items_sent < ITEM_TARGET) begin
            case (scen % 4)
                0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin send_idle_pct = 65; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 65; end
                default: begin send_idle_pct = 29; rsp_stall_pct = 29; end
            endcase
            wait_drained();

            broken = ($urandom_range(6) == 0);
            len    = $urandom_range(3, 20);
            if (scen == 1) begin
                len = 2 * NEST_LIMIT + 2;
                compose_too_deep();
            end
            else compose_program(len, broken);

            case (scen % 5)
                0: rep_pick = 16'd1;
                1: rep_pick = 16'd0;
                2: rep_pick = 16'hFFFF;
                default: rep_pick = $urandom_range(1, 3);
            endcase
            case ($urandom_range(5))
                0: spd_pick = 16'd1;
                1: spd_pick = 16'd100;
                2: spd_pick = 16'd0;
                3: spd_pick = 16'h007F;
                default: spd_pick = $urandom;
            endcase
            case ($urandom_range(9))
                0: len_pick = 16'd0;
                1: len_pick = 16'd256;
                2: len_pick = 16'h01FF;
                default: len_pick = len;
            endcase
            write_reg(CFG_REPEAT_LIMIT, rep_pick);
            write_reg(CFG_SPEED_TENTHS, spd_pick);
            write_reg(CFG_PROGRAM_LENGTH, len_pick);

            for (int i = 0; i < len; i++) begin
                cmd_t c;
                c = random_cmd(KIND_LOAD);
                c.load_index   = i;
                c.load_type    = pg_type[i];
                c.load_operand = pg_op[i];
                send_plain(c);
            end
            send_plain(random_cmd(KIND_START));

            // Long receiver hold-off so the block backs up into its input
            if (scen == 2) hold_token++;

            steps = $urandom_range(10, 60);
            for (int s = 0; s < steps; s++) begin
                if ($urandom_range(99) < 85) send_plain(random_cmd(KIND_STEP));
                else send_plain(random_cmd($urandom_range(7)));
            end
            scen++;
        end

        // Let the last responses come out, then settle
        wait_drained();
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending_rsp.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/nlas_pkg.sv
hdl/nlas_ram.sv
hdl/nlas_div.sv
hdl/nested_loop_action_sequencer.sv
bench/nested_loop_action_sequencer_tb.sv
